// ===== rtl/tsw_pkg.sv =====
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants of the tick sleep/wakeup table
// Result kinds, command codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package tsw_pkg;

	localparam int TID_W   = 8;
	localparam int TICKS_W = 32;
	localparam int NOW_W   = 63;
	localparam int KIND_W  = 2;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_SLEEP = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_SLEEP_OK   = 2'd0,
		KIND_FULL       = 2'd1,
		KIND_WOKEN      = 2'd2,
		KIND_IDLE_TICK  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

// ===== rtl/tsw_req_if.sv =====
// ----------------------------------------------------------------------------
// tsw_req_if: request channel
// Valid/ready channel carrying one command beat (tick or sleep request).
// ----------------------------------------------------------------------------
interface tsw_req_if;
	import tsw_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [TID_W-1:0]          thread_id;
	logic signed [TICKS_W-1:0] sleep_ticks;

	modport source (output valid, output cmd, output thread_id, output sleep_ticks,
		input ready);
	modport sink (input valid, input cmd, input thread_id, input sleep_ticks,
		output ready);
endinterface

// ===== rtl/tsw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tsw_rsp_if: result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface tsw_rsp_if;
	import tsw_pkg::*;

	logic             valid;
	logic             ready;
	kind_t            kind;
	logic [TID_W-1:0] woken_thread;
	logic [NOW_W-1:0] now_count;
	logic             last;

	modport source (output valid, output kind, output woken_thread, output now_count,
		output last, input ready);
	modport sink (input valid, input kind, input woken_thread, input now_count,
		input last, output ready);
endinterface

// ===== rtl/tsw_wake_calc.sv =====
// ----------------------------------------------------------------------------
// tsw_wake_calc: wake time computation
// Clamps negative requests to zero and saturates count + ticks at the top
// of the counter range.
// ----------------------------------------------------------------------------
module tsw_wake_calc #(
	parameter int COUNT_WIDTH = 64
) (
	input  logic [COUNT_WIDTH-1:0]          count,
	input  logic signed [tsw_pkg::TICKS_W-1:0] sleep_ticks,
	output logic [COUNT_WIDTH-1:0]          wake
);
	import tsw_pkg::*;

	localparam int SUM_W = ((COUNT_WIDTH > TICKS_W - 1) ? COUNT_WIDTH : TICKS_W - 1) + 1;

	logic [TICKS_W-2:0] add;
	logic [SUM_W-1:0]   sum;

	always_comb begin
		// negative request sleeps zero ticks
		add  = sleep_ticks[TICKS_W-1] ? '0 : sleep_ticks[TICKS_W-2:0];
		sum  = SUM_W'(count) + SUM_W'(add);
		wake = ((sum >> COUNT_WIDTH) != '0) ? '1 : sum[COUNT_WIDTH-1:0];
	end

endmodule

// ===== rtl/tsw_mem.sv =====
// ----------------------------------------------------------------------------
// tsw_mem: sleeper table storage
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module tsw_mem #(
	parameter int SLOTS       = 16,
	parameter int COUNT_WIDTH = 64,
	parameter int IDX_W       = 4
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [IDX_W-1:0]            waddr,
	input  logic [COUNT_WIDTH-1:0]      wdata_wake,
	input  logic [tsw_pkg::TID_W-1:0]   wdata_owner,
	input  logic [IDX_W-1:0]            raddr,
	output logic [COUNT_WIDTH-1:0]      rdata_wake,
	output logic [tsw_pkg::TID_W-1:0]   rdata_owner
);
	import tsw_pkg::*;

	logic [COUNT_WIDTH-1:0] wake_mem  [SLOTS];
	logic [TID_W-1:0]       owner_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			wake_mem[waddr]  <= wdata_wake;
			owner_mem[waddr] <= wdata_owner;
		end
		rdata_wake  <= wake_mem[raddr];
		rdata_owner <= owner_mem[raddr];
	end

endmodule

// ===== rtl/tick_sleep_wakeup_table.sv =====
// ----------------------------------------------------------------------------
// tick_sleep_wakeup_table: alarm-clock sleep queue
// Tick counter plus an arrival-ordered table of sleeping threads.
// ----------------------------------------------------------------------------
// A sleep request is stored at the tail of the table with
// wake time = count + ticks (negative ticks count as zero, saturating at the
// counter maximum) or rejected when the table is full, and gives one result.
// A tick bumps the counter and then walks the table one slot per cycle
// through the table memory's single read port, holding while a woken beat
// waits on the result side. Due sleepers are reported in arrival order, one
// beat each, the last one flagged; the rest are packed back toward the head
// of the table as the walk goes. A tick that wakes nobody gives one no-wake
// beat. No clearing pass is needed after reset: a fill count marks the
// occupied prefix of the table.
// ----------------------------------------------------------------------------
module tick_sleep_wakeup_table #(
	parameter int SLOTS       = 16,
	parameter int COUNT_WIDTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	tsw_req_if.sink   req,
	tsw_rsp_if.source rsp
);
	import tsw_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0] tick_q;
	logic [CNT_W-1:0]       fill_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       keep_q;
	logic                   pend_v_q;
	logic [TID_W-1:0]       pend_owner_q;

	logic                   rsp_v_q;
	kind_t                  rsp_kind_q;
	logic [TID_W-1:0]       rsp_tid_q;
	logic [NOW_W-1:0]       rsp_now_q;
	logic                   rsp_last_q;

	logic                   rsp_free;
	logic                   req_fire;
	logic                   table_full;
	logic [COUNT_WIDTH-1:0] wake_calc;
	logic [CNT_W-1:0]       idx_inc;

	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wwake;
	logic [TID_W-1:0]       mem_wowner;
	logic [IDX_W-1:0]       mem_raddr;
	logic [COUNT_WIDTH-1:0] rd_wake;
	logic [TID_W-1:0]       rd_owner;

	logic                   due;
	logic                   stall;
	logic                   advance;
	logic                   scan_done;
	logic                   push;
	kind_t                  push_kind;
	logic [TID_W-1:0]       push_tid;
	logic                   push_last;

	tsw_wake_calc #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_wake (
		.count      (tick_q),
		.sleep_ticks(req.sleep_ticks),
		.wake       (wake_calc)
	);

	tsw_mem #(
		.SLOTS      (SLOTS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.IDX_W      (IDX_W)
	) u_mem (
		.clk        (clk),
		.we         (mem_we),
		.waddr      (mem_waddr),
		.wdata_wake (mem_wwake),
		.wdata_owner(mem_wowner),
		.raddr      (mem_raddr),
		.rdata_wake (rd_wake),
		.rdata_owner(rd_owner)
	);

	assign rsp_free   = !rsp_v_q || rsp.ready;
	assign req.ready  = (state_q == ST_IDLE) && rsp_free;
	assign req_fire   = req.valid && req.ready;
	assign table_full = (fill_q == CNT_W'(SLOTS));
	assign idx_inc    = idx_q + CNT_W'(1);

	assign rsp.valid        = rsp_v_q;
	assign rsp.kind         = rsp_kind_q;
	assign rsp.woken_thread = rsp_tid_q;
	assign rsp.now_count    = rsp_now_q;
	assign rsp.last         = rsp_last_q;

	always_comb begin
		state_d    = state_q;
		due        = 1'b0;
		stall      = 1'b0;
		advance    = 1'b0;
		scan_done  = 1'b0;
		push       = 1'b0;
		push_kind  = KIND_SLEEP_OK;
		push_tid   = req.thread_id;
		push_last  = 1'b1;
		mem_we     = 1'b0;
		mem_waddr  = fill_q[IDX_W-1:0];
		mem_wwake  = wake_calc;
		mem_wowner = req.thread_id;
		mem_raddr  = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req.cmd == CMD_SLEEP) begin
						push      = 1'b1;
						push_kind = table_full ? KIND_FULL : KIND_SLEEP_OK;
						mem_we    = !table_full;
					end else begin
						state_d = (fill_q == '0) ? ST_FIN : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				due   = (rd_wake <= tick_q);
				// a second due sleeper needs the held one sent first
				stall = due && pend_v_q && !rsp_free;
				advance   = !stall;
				scan_done = advance && (idx_inc == fill_q);
				if (advance && due && pend_v_q) begin
					push      = 1'b1;
					push_kind = KIND_WOKEN;
					push_tid  = pend_owner_q;
					push_last = 1'b0;
				end
				if (advance && !due) begin
					// pack the survivor toward the head
					mem_we     = 1'b1;
					mem_waddr  = keep_q[IDX_W-1:0];
					mem_wwake  = rd_wake;
					mem_wowner = rd_owner;
				end
				mem_raddr = stall ? idx_q[IDX_W-1:0] : idx_inc[IDX_W-1:0];
				if (scan_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (rsp_free) begin
					push      = 1'b1;
					push_kind = pend_v_q ? KIND_WOKEN : KIND_IDLE_TICK;
					push_tid  = pend_v_q ? pend_owner_q : '0;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			fill_q   <= '0;
			idx_q    <= '0;
			keep_q   <= '0;
			pend_v_q <= 1'b0;
			rsp_v_q  <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && req_fire) begin
				if (req.cmd == CMD_SLEEP) begin
					if (!table_full)
						fill_q <= fill_q + CNT_W'(1);
				end else begin
					tick_q   <= tick_q + COUNT_WIDTH'(1);
					idx_q    <= '0;
					keep_q   <= '0;
					pend_v_q <= 1'b0;
				end
			end
			if (state_q == ST_SCAN && advance) begin
				idx_q <= idx_inc;
				if (due)
					pend_v_q <= 1'b1;
				else
					keep_q <= keep_q + CNT_W'(1);
			end
			if (state_q == ST_FIN && rsp_free) begin
				fill_q   <= keep_q;
				pend_v_q <= 1'b0;
			end
			if (push)
				rsp_v_q <= 1'b1;
			else if (rsp.ready)
				rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && advance && due)
			pend_owner_q <= rd_owner;
		if (push) begin
			rsp_kind_q <= push_kind;
			rsp_tid_q  <= push_tid;
			rsp_now_q  <= (state_q == ST_IDLE) ? NOW_W'(tick_q) : NOW_W'(tick_q);
			rsp_last_q <= push_last;
		end
	end

endmodule

// ===== rtl/tsw_check.sv =====
// ----------------------------------------------------------------------------
// tsw_check: port-level checks for the sleep/wakeup table
// Watches the request and result channels; bound onto the top level.
// ----------------------------------------------------------------------------
module tsw_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_cmd,
	input logic [tsw_pkg::TID_W-1:0]   req_thread_id,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [tsw_pkg::KIND_W-1:0]  rsp_kind,
	input logic [tsw_pkg::TID_W-1:0]   rsp_woken_thread,
	input logic [tsw_pkg::NOW_W-1:0]   rsp_now_count,
	input logic                        rsp_last
);
	import tsw_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
		rsp_valid && $stable(rsp_kind) && $stable(rsp_woken_thread)
		&& $stable(rsp_now_count) && $stable(rsp_last))
		else $error("result beat changed while stalled");

	// a request is taken only when the result register can take a beat
	a_req_room: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (!rsp_valid || rsp_ready))
		else $error("request taken while result side blocked");

	// a sleep request answers with one final beat on the next cycle
	a_sleep_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd == CMD_SLEEP |=>
		rsp_valid && rsp_last && rsp_woken_thread == $past(req_thread_id)
		&& (rsp_kind == KIND_SLEEP_OK || rsp_kind == KIND_FULL))
		else $error("sleep request not answered");

	// a no-wake beat closes its tick and carries no thread
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_IDLE_TICK |-> rsp_last && rsp_woken_thread == '0)
		else $error("malformed no-wake beat");

endmodule

bind tick_sleep_wakeup_table tsw_check u_tsw_check (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_cmd         (req.cmd),
	.req_thread_id   (req.thread_id),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_kind        (rsp.kind),
	.rsp_woken_thread(rsp.woken_thread),
	.rsp_now_count   (rsp.now_count),
	.rsp_last        (rsp.last)
);

// ===== tb/tb_tick_sleep_wakeup_table.sv =====
// ----------------------------------------------------------------------------
// tb_tick_sleep_wakeup_table: testbench of the tick sleep/wakeup table
// Drives tick and sleep commands with bursty valid timing and a patterned
// ready stall. A shadow copy of the counter and sleeper table predicts every
// result beat, and each returned beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_tick_sleep_wakeup_table;
	timeunit 1ns;
	timeprecision 1ps;

	import tsw_pkg::*;

	localparam int TABLE_DEPTH   = 16;
	localparam int CNT_W         = 64;
	localparam int RANDOM_BEATS  = 300;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;

	typedef struct packed {
		kind_t            kind;
		logic [TID_W-1:0] thread;
		logic [NOW_W-1:0] now;
		logic             last;
	} report_t;

	typedef struct {
		logic [TID_W-1:0] owner;
		logic [CNT_W-1:0] wake_at;
	} sleeper_t;

	logic clk;
	logic arst_n;

	tsw_req_if req_ch ();
	tsw_rsp_if rsp_ch ();

	tick_sleep_wakeup_table #(
		.SLOTS       (TABLE_DEPTH),
		.COUNT_WIDTH (CNT_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow of the block state
	logic [CNT_W-1:0] shadow_count;
	sleeper_t         shadow_sleepers[$];
	report_t          owed_reports[$];

	int beats_sent;
	int sleeps_stored;
	int sleeps_refused;
	int wakeups;
	int quiet_ticks;
	int mismatches = 0;
	int burst_left;
	int stall_cycles = 0;
	int ready_mode = 0;
	int mode_left = 0;
	int ready_phase = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Update the shadow table for one accepted command and queue its reports.
	function automatic void apply_to_table(input logic cmd, input logic [TID_W-1:0] tid,
		input logic signed [TICKS_W-1:0] ticks);
		sleeper_t         kept[$];
		logic [TID_W-1:0] woken[$];
		logic [CNT_W:0]   add;
		logic [CNT_W:0]   sum;
		sleeper_t         entry;
		if (cmd == CMD_SLEEP) begin
			if (shadow_sleepers.size() >= TABLE_DEPTH) begin
				owed_reports.push_back('{kind: KIND_FULL, thread: tid,
					now: shadow_count[NOW_W-1:0], last: 1'b1});
				sleeps_refused++;
			end else begin
				// negative ticks sleep zero, far wake times saturate
				add = ticks[TICKS_W-1] ? '0 : {{(CNT_W + 1 - TICKS_W){1'b0}}, ticks};
				sum = {1'b0, shadow_count} + add;
				entry.owner = tid;
				entry.wake_at = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
				shadow_sleepers.push_back(entry);
				owed_reports.push_back('{kind: KIND_SLEEP_OK, thread: tid,
					now: shadow_count[NOW_W-1:0], last: 1'b1});
				sleeps_stored++;
			end
		end else begin
			shadow_count = shadow_count + 1'b1;
			foreach (shadow_sleepers[i]) begin
				if (shadow_sleepers[i].wake_at <= shadow_count)
					woken.push_back(shadow_sleepers[i].owner);
				else
					kept.push_back(shadow_sleepers[i]);
			end
			shadow_sleepers = kept;
			if (woken.size() == 0) begin
				owed_reports.push_back('{kind: KIND_IDLE_TICK, thread: '0,
					now: shadow_count[NOW_W-1:0], last: 1'b1});
				quiet_ticks++;
			end else begin
				foreach (woken[i])
					owed_reports.push_back('{kind: KIND_WOKEN, thread: woken[i],
						now: shadow_count[NOW_W-1:0], last: (i == woken.size() - 1)});
				wakeups += woken.size();
			end
		end
	endfunction

	// Send one command beat, opening a gap between bursts now and then.
	task automatic send_beat(input logic cmd, input logic [TID_W-1:0] tid,
		input logic signed [TICKS_W-1:0] ticks);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
		end
		burst_left--;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= cmd;
		req_ch.thread_id   <= tid;
		req_ch.sleep_ticks <= ticks;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		apply_to_table(cmd, tid, ticks);
		beats_sent++;
	endtask

	task automatic send_tick();
		send_beat(CMD_TICK, TID_W'($urandom), TICKS_W'($urandom));
	endtask

	task automatic test_idle_tick();
		send_tick();
	endtask

	// Several sleepers due on one tick wake in arrival order; a later one stays.
	task automatic test_wake_order();
		send_beat(CMD_SLEEP, 8'd0, 32'sd0);
		send_beat(CMD_SLEEP, 8'd20, 32'sd5);
		send_beat(CMD_SLEEP, 8'd255, 32'sd1);
		send_beat(CMD_SLEEP, 8'd10, -32'sd1);
		send_beat(CMD_SLEEP, 8'd11, 32'sh8000_0000);
		send_tick();
	endtask

	// Fill the table, repeat one thread id, then get a refusal and tick the due sleepers out.
	task automatic test_table_full();
		// this sleeper never comes due within the run
		send_beat(CMD_SLEEP, 8'hA5, 32'sh7FFF_FFFF);
		for (int i = 0; shadow_sleepers.size() < TABLE_DEPTH; i++)
			send_beat(CMD_SLEEP, (i == 3 || i == 9) ? 8'd7 : TID_W'(i + 40),
				(i == 3) ? 32'sd1 : (i == 9) ? 32'sd3 : TICKS_W'(i % 4));
		send_beat(CMD_SLEEP, 8'd200, 32'sd2);
		repeat (4) send_tick();
	endtask

	task automatic test_random_traffic();
		int start;
		int n;
		logic [TID_W-1:0] tid;
		start = beats_sent;
		while (beats_sent - start < RANDOM_BEATS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					// a few sleepers, then enough ticks to wake some of them
					tid = TID_W'($urandom);
					n = $urandom_range(1, 5);
					repeat (n) begin
						if ($urandom_range(0, 3) != 0)
							tid = TID_W'($urandom);
						send_beat(CMD_SLEEP, tid, TICKS_W'($urandom_range(0, 8)));
					end
					n = $urandom_range(1, 10);
					repeat (n) send_tick();
				end
				6: begin
					while (shadow_sleepers.size() < TABLE_DEPTH)
						send_beat(CMD_SLEEP, TID_W'($urandom), TICKS_W'($urandom_range(0, 12)));
					n = $urandom_range(1, 2);
					repeat (n) send_beat(CMD_SLEEP, TID_W'($urandom), TICKS_W'($urandom));
					for (int k = 0; k < 25 && shadow_sleepers.size() > 1; k++)
						send_tick();
				end
				default: begin
					n = $urandom_range(1, 8);
					repeat (n) begin
						case ($urandom_range(0, 2))
							0: send_tick();
							1: send_beat(CMD_SLEEP, TID_W'($urandom),
								{1'b1, 31'($urandom)});
							default: send_beat(CMD_SLEEP, TID_W'($urandom),
								TICKS_W'($urandom_range(0, 40)));
						endcase
					end
				end
			endcase
		end
	endtask

	// Result side: check each beat, then pick the next ready value.
	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = '{kind: rsp_ch.kind, thread: rsp_ch.woken_thread,
				now: rsp_ch.now_count, last: rsp_ch.last};
			if (owed_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected beat kind=%0d thread=%0d now=%0d last=%0b",
						$realtime, got.kind, got.thread, got.now, got.last);
			end else begin
				want = owed_reports.pop_front();
				if (got.kind !== want.kind || got.thread !== want.thread ||
					got.now !== want.now || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: mismatch expected kind=%0d thread=%0d now=%0d last=%0b",
							" got kind=%0d thread=%0d now=%0d last=%0b"}, $realtime,
							want.kind, want.thread, want.now, want.last,
							got.kind, got.thread, got.now, got.last);
				end
			end
		end
		// stall modes: always ready, coin flip, one cycle in four
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(10, 80);
		end
		mode_left--;
		ready_phase++;
		case (ready_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: rsp_ch.ready <= (ready_phase % 4 == 0);
		endcase
	end

	// Watchdog: end the run when no beat moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= IDLE_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles, %0d reports owed",
					IDLE_LIMIT, owed_reports.size());
				$display("tb_tick_sleep_wakeup_table failed");
				$finish;
			end
		end
	end

	initial begin
		shadow_count = '0;
		beats_sent = 0;
		sleeps_stored = 0;
		sleeps_refused = 0;
		wakeups = 0;
		quiet_ticks = 0;
		burst_left = 0;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.cmd         <= CMD_TICK;
		req_ch.thread_id   <= '0;
		req_ch.sleep_ticks <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_tick();
		test_wake_order();
		test_table_full();
		test_random_traffic();

		req_ch.valid <= 1'b0;
		while (owed_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d command beats: %0d sleeps stored, %0d refused on a full table",
			beats_sent, sleeps_stored, sleeps_refused);
		$display("%0d threads woken, %0d ticks with nobody due, %0d mismatches",
			wakeups, quiet_ticks, mismatches);
		if (mismatches == 0)
			$display("tb_tick_sleep_wakeup_table passed");
		else
			$display("tb_tick_sleep_wakeup_table failed");
		$finish;
	end

endmodule

// ===== tick_sleep_wakeup_table.f =====
rtl/tsw_pkg.sv
rtl/tsw_req_if.sv
rtl/tsw_rsp_if.sv
rtl/tsw_wake_calc.sv
rtl/tsw_mem.sv
rtl/tick_sleep_wakeup_table.sv
rtl/tsw_check.sv
tb/tb_tick_sleep_wakeup_table.sv
